// File: rtl/baro_pressure_compensation_macros.svh
// Assertion macros for the barometric pressure compensation block.
`ifndef BARO_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_PRESSURE_COMPENSATION_MACROS_SVH

// Checked outside reset only.
`define BPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BPC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bpc_pkg.sv
// Types and constants for the barometric pressure compensation block.
`default_nettype none

package bpc_pkg;

	// configuration register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_SENS      = 3'd0;
	localparam logic [2:0] REG_OFFSET    = 3'd1;
	localparam logic [2:0] REG_SENS_TC   = 3'd2;
	localparam logic [2:0] REG_OFFSET_TC = 3'd3;
	localparam logic [2:0] REG_TREF      = 3'd4;
	localparam logic [2:0] REG_TSENS     = 3'd5;

	localparam int ADDR_W = 5;

	// compensation constants
	localparam logic signed [18:0] TEMP_NOMINAL  = 19'sd2000;  // 20.00 C
	localparam logic signed [18:0] TEMP_VCOLD    = -19'sd1500; // -15.00 C
	localparam logic signed [19:0] TEMP_NOM_X    = 20'sd2000;
	localparam logic signed [19:0] TEMP_VCOLD_X  = 20'sd1500;
	localparam logic signed [41:0] TEMP_NOM_WIDE = 42'sd2000;
	localparam int TEMP_SHIFT   = 23;
	localparam int OFF_SHIFT    = 7;
	localparam int SENS_SHIFT   = 8;
	localparam int P_MUL_SHIFT  = 21;
	localparam int P_OUT_SHIFT  = 15;

	typedef struct packed {
		logic [23:0] raw_temperature;
		logic [23:0] raw_pressure;
	} sample_t;

	typedef struct packed {
		logic signed [18:0] temp_centideg;
		logic signed [31:0] pressure_pa;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/baro_pressure_compensation.sv
// Top level: seven-stage barometric pressure compensation pipeline with APB coefficients.
// A transaction accepted into S1 moves through the registered stages S2 to S7 to the result.
// Throughput: one sample pair per cycle while result_ready is high; the multiplier stages
// (temperature products, squares, and the split D1 * SENS product) are each registered.
// A stall holds only the full stages, so bubbles are squeezed out and sample_ready
// drops only when all seven stages hold data. Reset clears the valid bits and coefficients.
`default_nettype none

`include "baro_pressure_compensation_macros.svh"

module baro_pressure_compensation import bpc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// sample channel
	input  wire logic              sample_valid,
	output logic                   sample_ready,
	input  wire sample_t           sample,
	// result channel
	output logic                   result_valid,
	input  wire logic              result_ready,
	output result_t                result,
	// APB configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	// ------------------------------------------------------------------
	// Coefficient registers C1..C6
	// ------------------------------------------------------------------
	logic [15:0] coef_sens_q, coef_offset_q, coef_sens_tc_q;
	logic [15:0] coef_offset_tc_q, coef_tref_q, coef_tsens_q;
	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_sens_q      <= '0;
			coef_offset_q    <= '0;
			coef_sens_tc_q   <= '0;
			coef_offset_tc_q <= '0;
			coef_tref_q      <= '0;
			coef_tsens_q     <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_SENS:      coef_sens_q      <= pwdata[15:0];
				REG_OFFSET:    coef_offset_q    <= pwdata[15:0];
				REG_SENS_TC:   coef_sens_tc_q   <= pwdata[15:0];
				REG_OFFSET_TC: coef_offset_tc_q <= pwdata[15:0];
				REG_TREF:      coef_tref_q      <= pwdata[15:0];
				REG_TSENS:     coef_tsens_q     <= pwdata[15:0];
				default: ; // unmapped index: write dropped
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_SENS:      prdata = {16'h0, coef_sens_q};
			REG_OFFSET:    prdata = {16'h0, coef_offset_q};
			REG_SENS_TC:   prdata = {16'h0, coef_sens_tc_q};
			REG_OFFSET_TC: prdata = {16'h0, coef_offset_tc_q};
			REG_TREF:      prdata = {16'h0, coef_tref_q};
			REG_TSENS:     prdata = {16'h0, coef_tsens_q};
			default:       prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Flow control: per-stage valid bits, ready ripples back from output.
	// A stage loads whenever it is empty or the stage after it moves.
	// ------------------------------------------------------------------
	logic [7:1] v_q;
	logic [7:1] v_prev;
	logic [8:1] rdy;

	assign v_prev = {v_q[6:1], sample_valid};

	always_comb begin
		rdy[8] = result_ready;
		for (int k = 7; k >= 1; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end

	assign sample_ready = rdy[1];
	assign result_valid = v_q[7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= 7; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_prev[k];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// S1: dT = D2 - C5 * 2^8
	// ------------------------------------------------------------------
	logic signed [24:0] dt_w, dt_s1;
	logic        [23:0] d1_s1;

	assign dt_w = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, coef_tref_q, 8'h00});

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			dt_s1 <= dt_w;
			d1_s1 <= sample.raw_pressure;
		end
	end

	// ------------------------------------------------------------------
	// S2: three parallel dT products (25 x 17 signed)
	// ------------------------------------------------------------------
	logic signed [41:0] prod_tsens_s2, prod_off_s2, prod_sens_s2;
	logic        [23:0] d1_s2;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			prod_tsens_s2 <= dt_s1 * $signed({1'b0, coef_tsens_q});
			prod_off_s2   <= dt_s1 * $signed({1'b0, coef_offset_tc_q});
			prod_sens_s2  <= dt_s1 * $signed({1'b0, coef_sens_tc_q});
			d1_s2         <= d1_s1;
		end
	end

	// ------------------------------------------------------------------
	// S3: first-order TEMP, OFF, SENS
	// ------------------------------------------------------------------
	logic signed [41:0] temp_w, off1_w, sens1_w;
	logic signed [18:0] temp_s3;
	logic signed [41:0] off1_s3, sens1_s3;
	logic        [23:0] d1_s3;

	assign temp_w  = (prod_tsens_s2 >>> TEMP_SHIFT) + TEMP_NOM_WIDE;
	assign off1_w  = $signed({10'h0, coef_offset_q, 16'h0000}) + (prod_off_s2 >>> OFF_SHIFT);
	assign sens1_w = $signed({11'h0, coef_sens_q, 15'h0000}) + (prod_sens_s2 >>> SENS_SHIFT);

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			temp_s3  <= temp_w[18:0]; // always fits in 19 bits
			off1_s3  <= off1_w;
			sens1_s3 <= sens1_w;
			d1_s3    <= d1_s2;
		end
	end

	// ------------------------------------------------------------------
	// S4: squares for the cold corrections, range flags
	// ------------------------------------------------------------------
	logic signed [19:0] temp_x, dm_w, em_w;
	logic signed [39:0] sq_d_s4, sq_e_s4;
	logic               cold_s4, vcold_s4;
	logic signed [18:0] temp_s4;
	logic signed [41:0] off1_s4, sens1_s4;
	logic        [23:0] d1_s4;

	assign temp_x = $signed({temp_s3[18], temp_s3});
	assign dm_w   = temp_x - TEMP_NOM_X;
	assign em_w   = temp_x + TEMP_VCOLD_X;

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			sq_d_s4  <= dm_w * dm_w;
			sq_e_s4  <= em_w * em_w;
			cold_s4  <= temp_s3 < TEMP_NOMINAL;
			vcold_s4 <= temp_s3 < TEMP_VCOLD;
			temp_s4  <= temp_s3;
			off1_s4  <= off1_s3;
			sens1_s4 <= sens1_s3;
			d1_s4    <= d1_s3;
		end
	end

	// ------------------------------------------------------------------
	// S5: OFF2 / SENS2 by shift-add, subtract from first order
	// ------------------------------------------------------------------
	logic [41:0] sqd_x, sqe_x, five_d, seven_e, eleven_e, off2_w, sens2_w;
	logic signed [41:0] off_s5, sens_s5;
	logic signed [18:0] temp_s5;
	logic        [23:0] d1_s5;

	assign sqd_x    = {2'b00, sq_d_s4};   // squares are never negative
	assign sqe_x    = {2'b00, sq_e_s4};
	assign five_d   = (sqd_x << 2) + sqd_x;
	assign seven_e  = (sqe_x << 3) - sqe_x;
	assign eleven_e = (sqe_x << 3) + (sqe_x << 1) + sqe_x;

	always_comb begin
		off2_w  = '0;
		sens2_w = '0;
		if (cold_s4) begin
			off2_w  = five_d >> 1;
			sens2_w = five_d >> 2;
			if (vcold_s4) begin
				off2_w  = (five_d >> 1) + seven_e;
				sens2_w = (five_d >> 2) + (eleven_e >> 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			off_s5  <= off1_s4 - $signed(off2_w);
			sens_s5 <= sens1_s4 - $signed(sens2_w);
			temp_s5 <= temp_s4;
			d1_s5   <= d1_s4;
		end
	end

	// ------------------------------------------------------------------
	// S6: D1 * SENS split into low (unsigned) and high (signed) halves
	// ------------------------------------------------------------------
	logic        [44:0] plo_s6;
	logic signed [45:0] phi_s6;
	logic signed [41:0] off_s6;
	logic signed [18:0] temp_s6;

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			plo_s6  <= d1_s5 * sens_s5[20:0];
			phi_s6  <= $signed({1'b0, d1_s5}) * $signed(sens_s5[41:21]);
			off_s6  <= off_s5;
			temp_s6 <= temp_s5;
		end
	end

	// ------------------------------------------------------------------
	// S7: (D1*SENS >> 21) = hi + (lo >> 21); P = (that - OFF) >> 15
	// ------------------------------------------------------------------
	logic signed [46:0] q_w, r_w;
	result_t            result_s7;

	assign q_w = $signed({phi_s6[45], phi_s6}) + $signed({23'h0, plo_s6[44:P_MUL_SHIFT]});
	assign r_w = q_w - $signed({{5{off_s6[41]}}, off_s6});

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			result_s7.temp_centideg <= temp_s6;
			result_s7.pressure_pa   <= r_w[46:P_OUT_SHIFT];
		end
	end

	assign result = result_s7;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`BPC_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !result_valid, "result valid during reset")
	`BPC_ASSERT(a_full_when_blocked, !sample_ready |-> (&v_q), "input blocked with a bubble")
	`BPC_ASSERT(a_s1_hold, (v_q[1] && !rdy[2]) |=> (v_q[1] && $stable(dt_s1)), "stage 1 lost data")
	`BPC_ASSERT(a_warm_no_corr, (rdy[5] && v_q[4] && !cold_s4) |=> (off_s5 == $past(off1_s4)), "warm correction applied")
	`BPC_ASSERT(a_cfg_tsens, (cfg_wr && cfg_idx == REG_TSENS) |=> (coef_tsens_q == $past(pwdata[15:0])), "C6 write lost")

endmodule

`default_nettype wire
